### rtl/sensor_frame_crc_check_and_convert_defines.svh
// assertion macros for the sensor frame checker
`ifndef SENSOR_FRAME_CRC_CHECK_AND_CONVERT_DEFINES_SVH
`define SENSOR_FRAME_CRC_CHECK_AND_CONVERT_DEFINES_SVH

// same-cycle implication, off while reset is high
`define SFCCC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off while reset is high
`define SFCCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/sfccc_pkg.sv
// package: constants, byte position codes and crc-8 function for the frame checker
package sfccc_pkg;

   localparam logic [7:0]  CRC_POLY    = 8'h31;
   localparam logic [7:0]  CRC_INIT    = 8'hFF;
   localparam logic [14:0] TEMP_SCALE  = 15'd17500;
   localparam logic [13:0] HUM_SCALE   = 14'd10000;
   localparam logic [14:0] TEMP_OFFSET = 15'd4500;

   localparam int RSP_DATA_W = 64;
   localparam int RSP_USER_W = 3;

   typedef enum logic [2:0] {
      POS_TEMP_HI  = 3'd0,
      POS_TEMP_LO  = 3'd1,
      POS_TEMP_CRC = 3'd2,
      POS_HUM_HI   = 3'd3,
      POS_HUM_LO   = 3'd4,
      POS_HUM_CRC  = 3'd5
   } pos_type;

   // crc-8, msb first, no final xor
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

### rtl/sensor_frame_crc_check_and_convert.sv
// top level: six-byte sensor frame crc checker and fixed-point converter
//
// The req channel takes one frame byte per word: temperature high, low, crc,
// humidity high, low, crc. req_tuser marks the first byte of a frame and
// restarts byte counting; a partial frame is dropped. Without the mark the
// frame wraps after the sixth byte, so frames may follow back to back.
// Each 16-bit word is checked with crc-8 (poly 0x31, init 0xFF, msb first).
// After the sixth byte one rsp word carries both raw words, the converted
// temperature (hundredths of a degree C) and humidity (hundredths of a percent),
// and the crc flags. Bytes other than the sixth give no rsp word.
// Throughput is one byte per cycle while req_tready is high. After the sixth
// byte is accepted, one stage registers the constant products and the next
// does the divide-by-65535 correction and offset into the output register.
// When rsp_tready is low the output register holds its word and the product
// stage fills; req_tready drops only when both are full.
// Synchronous reset restarts the byte position and crc and clears all valid flags.
`include "sensor_frame_crc_check_and_convert_defines.svh"

module sensor_frame_crc_check_and_convert (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,  // rx_byte
   input  logic [0:0]                          req_tuser,  // frame_start
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // temperature_centi[14:0], humidity_centi[28:15], raw_temperature[44:29],
   // raw_humidity[60:45], zero fill[63:61]
   output logic [sfccc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // temp_crc_good, humid_crc_good, frame_valid
   output logic [sfccc_pkg::RSP_USER_W-1:0]    rsp_tuser
);

   // frame state
   sfccc_pkg::pos_type byte_pos_ff, byte_pos_in, pos_eff;
   logic [7:0]  crc_ff, crc_in, crc_base;
   logic [15:0] temp_word_ff, temp_word_in;
   logic [15:0] hum_word_ff, hum_word_in;
   logic        temp_good_ff, temp_good_in;

   // product stage
   logic        s1_valid_ff, s1_valid_in;
   logic [30:0] s1_temp_prod_ff, s1_temp_prod_in;
   logic [29:0] s1_hum_prod_ff, s1_hum_prod_in;
   logic [15:0] s1_raw_temp_ff;
   logic [15:0] s1_raw_hum_ff;
   logic        s1_temp_good_ff;
   logic        s1_hum_good_ff, s1_hum_good_in;

   // output stage
   logic        rsp_valid_ff, rsp_valid_in;
   logic [14:0] rsp_temp_ff, rsp_temp_in;
   logic [13:0] rsp_hum_ff, rsp_hum_in;
   logic [15:0] rsp_raw_temp_ff;
   logic [15:0] rsp_raw_hum_ff;
   logic        rsp_temp_good_ff;
   logic        rsp_hum_good_ff;

   logic        out_open, s1_open, s1_advance, accept, result_byte;
   logic [30:0] temp_sum;
   logic [29:0] hum_sum;

   assign out_open   = !rsp_valid_ff || rsp_tready;
   assign s1_advance = s1_valid_ff && out_open;
   assign s1_open    = !s1_valid_ff || out_open;
   assign req_tready = s1_open;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      if (req_tuser[0] || (byte_pos_ff > sfccc_pkg::POS_HUM_CRC)) begin
         pos_eff  = sfccc_pkg::POS_TEMP_HI;
         crc_base = sfccc_pkg::CRC_INIT;
      end else begin
         pos_eff  = byte_pos_ff;
         crc_base = crc_ff;
      end
   end

   assign result_byte = accept && (pos_eff == sfccc_pkg::POS_HUM_CRC);

   // frame state next values
   always_comb begin
      byte_pos_in    = byte_pos_ff;
      crc_in         = crc_ff;
      temp_word_in   = temp_word_ff;
      hum_word_in    = hum_word_ff;
      temp_good_in   = temp_good_ff;
      s1_hum_good_in = (crc_base == req_tdata);
      if (accept) begin
         case (pos_eff)
            sfccc_pkg::POS_TEMP_HI: begin
               crc_in       = sfccc_pkg::crc8_byte(sfccc_pkg::CRC_INIT, req_tdata);
               temp_word_in = {req_tdata, 8'h00};
               byte_pos_in  = sfccc_pkg::POS_TEMP_LO;
            end
            sfccc_pkg::POS_TEMP_LO: begin
               crc_in       = sfccc_pkg::crc8_byte(crc_base, req_tdata);
               temp_word_in = {temp_word_ff[15:8], req_tdata};
               byte_pos_in  = sfccc_pkg::POS_TEMP_CRC;
            end
            sfccc_pkg::POS_TEMP_CRC: begin
               temp_good_in = (crc_base == req_tdata);
               crc_in       = sfccc_pkg::CRC_INIT;
               byte_pos_in  = sfccc_pkg::POS_HUM_HI;
            end
            sfccc_pkg::POS_HUM_HI: begin
               crc_in      = sfccc_pkg::crc8_byte(sfccc_pkg::CRC_INIT, req_tdata);
               hum_word_in = {req_tdata, 8'h00};
               byte_pos_in = sfccc_pkg::POS_HUM_LO;
            end
            sfccc_pkg::POS_HUM_LO: begin
               crc_in      = sfccc_pkg::crc8_byte(crc_base, req_tdata);
               hum_word_in = {hum_word_ff[15:8], req_tdata};
               byte_pos_in = sfccc_pkg::POS_HUM_CRC;
            end
            sfccc_pkg::POS_HUM_CRC: begin
               crc_in      = sfccc_pkg::CRC_INIT;
               byte_pos_in = sfccc_pkg::POS_TEMP_HI;
            end
            default: begin
               crc_in      = sfccc_pkg::CRC_INIT;
               byte_pos_in = sfccc_pkg::POS_TEMP_HI;
            end
         endcase
      end
   end

   // constant products of the finished words
   assign s1_temp_prod_in = 31'(temp_word_ff) * 31'(sfccc_pkg::TEMP_SCALE);
   assign s1_hum_prod_in  = 30'(hum_word_ff) * 30'(sfccc_pkg::HUM_SCALE);
   assign s1_valid_in     = result_byte || (s1_valid_ff && !out_open);

   // floor(x / 65535) = (x + (x >> 16) + 1) >> 16 for these ranges
   assign temp_sum    = s1_temp_prod_ff + 31'(s1_temp_prod_ff[30:16]) + 31'd1;
   assign hum_sum     = s1_hum_prod_ff + 30'(s1_hum_prod_ff[29:16]) + 30'd1;
   assign rsp_temp_in = temp_sum[30:16] - sfccc_pkg::TEMP_OFFSET;
   assign rsp_hum_in  = hum_sum[29:16];
   assign rsp_valid_in = s1_valid_ff || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff  <= sfccc_pkg::POS_TEMP_HI;
         crc_ff       <= sfccc_pkg::CRC_INIT;
         temp_word_ff <= 16'h0000;
         hum_word_ff  <= 16'h0000;
         temp_good_ff <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         byte_pos_ff  <= byte_pos_in;
         crc_ff       <= crc_in;
         temp_word_ff <= temp_word_in;
         hum_word_ff  <= hum_word_in;
         temp_good_ff <= temp_good_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result_byte) begin
         s1_temp_prod_ff <= s1_temp_prod_in;
         s1_hum_prod_ff  <= s1_hum_prod_in;
         s1_raw_temp_ff  <= temp_word_ff;
         s1_raw_hum_ff   <= hum_word_ff;
         s1_temp_good_ff <= temp_good_ff;
         s1_hum_good_ff  <= s1_hum_good_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_temp_ff      <= rsp_temp_in;
         rsp_hum_ff       <= rsp_hum_in;
         rsp_raw_temp_ff  <= s1_raw_temp_ff;
         rsp_raw_hum_ff   <= s1_raw_hum_ff;
         rsp_temp_good_ff <= s1_temp_good_ff;
         rsp_hum_good_ff  <= s1_hum_good_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_raw_hum_ff, rsp_raw_temp_ff, rsp_hum_ff, rsp_temp_ff};
   assign rsp_tuser  = {rsp_temp_good_ff & rsp_hum_good_ff, rsp_hum_good_ff, rsp_temp_good_ff};

   `SFCCC_ASSERT_NEXT(a_sixth_byte_fills_stage, clock, reset, result_byte, s1_valid_ff,
      "sixth byte did not reach the product stage")
   `SFCCC_ASSERT_NEXT(a_stage_holds_on_stall, clock, reset, s1_valid_ff && !out_open,
      s1_valid_ff && $stable(s1_temp_prod_ff) && $stable(s1_hum_prod_ff),
      "product stage lost a word while the output was full")
   `SFCCC_ASSERT_NOW(a_temp_range, clock, reset, rsp_valid_ff,
      ($signed(rsp_temp_ff) >= -15'sd4500) && ($signed(rsp_temp_ff) <= 15'sd13000),
      "temperature out of range")
   `SFCCC_ASSERT_NOW(a_hum_range, clock, reset, rsp_valid_ff, rsp_hum_ff <= 14'd10000,
      "humidity out of range")

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// testbench for the sensor frame crc checker and fixed-point converter
module tb;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 10;
   localparam int TOTAL_BYTES    = 2020;

   class frame_scoreboard;
      typedef struct packed {
         logic [14:0] temp_centi;
         logic [13:0] hum_centi;
         logic [15:0] raw_temp;
         logic [15:0] raw_hum;
         logic        temp_ok;
         logic        hum_ok;
         logic        both_ok;
      } reading_type;

      sfccc_pkg::pos_type next_pos;
      logic [7:0]         crc_acc;
      logic [15:0]        t_word;
      logic [15:0]        h_word;
      logic               t_ok;
      reading_type        reading_q[$];
      int                 errors;
      int                 checked;
      int                 bytes_seen;
      int                 bad_frames;

      function new();
         next_pos   = sfccc_pkg::POS_TEMP_HI;
         crc_acc    = sfccc_pkg::CRC_INIT;
         t_word     = '0;
         h_word     = '0;
         t_ok       = 1'b0;
         errors     = 0;
         checked    = 0;
         bytes_seen = 0;
         bad_frames = 0;
      endfunction

      // bit-serial crc-8, msb first
      static function logic [7:0] crc_step(logic [7:0] crc, logic [7:0] d);
         logic [7:0] c;
         logic       fb;
         c = crc;
         for (int i = 7; i >= 0; i--) begin
            fb = c[7] ^ d[i];
            c  = {c[6:0], 1'b0};
            if (fb) begin
               c = c ^ sfccc_pkg::CRC_POLY;
            end
         end
         return c;
      endfunction

      static function logic [7:0] word_crc(logic [15:0] w);
         return crc_step(crc_step(sfccc_pkg::CRC_INIT, w[15:8]), w[7:0]);
      endfunction

      function int pending();
         return reading_q.size();
      endfunction

      function void note_byte(logic [7:0] rx, logic start);
         reading_type r;
         logic [31:0] tq;
         logic [31:0] hq;
         logic        h_ok;
         bytes_seen++;
         if (start) begin
            next_pos = sfccc_pkg::POS_TEMP_HI;
            crc_acc  = sfccc_pkg::CRC_INIT;
         end
         case (next_pos)
            sfccc_pkg::POS_TEMP_HI: begin
               crc_acc  = crc_step(sfccc_pkg::CRC_INIT, rx);
               t_word   = {rx, 8'h00};
               next_pos = sfccc_pkg::POS_TEMP_LO;
            end
            sfccc_pkg::POS_TEMP_LO: begin
               crc_acc  = crc_step(crc_acc, rx);
               t_word   = {t_word[15:8], rx};
               next_pos = sfccc_pkg::POS_TEMP_CRC;
            end
            sfccc_pkg::POS_TEMP_CRC: begin
               t_ok     = (crc_acc == rx);
               crc_acc  = sfccc_pkg::CRC_INIT;
               next_pos = sfccc_pkg::POS_HUM_HI;
            end
            sfccc_pkg::POS_HUM_HI: begin
               crc_acc  = crc_step(sfccc_pkg::CRC_INIT, rx);
               h_word   = {rx, 8'h00};
               next_pos = sfccc_pkg::POS_HUM_LO;
            end
            sfccc_pkg::POS_HUM_LO: begin
               crc_acc  = crc_step(crc_acc, rx);
               h_word   = {h_word[15:8], rx};
               next_pos = sfccc_pkg::POS_HUM_CRC;
            end
            default: begin
               h_ok         = (crc_acc == rx);
               tq           = (32'd17500 * {16'd0, t_word}) / 32'd65535;
               hq           = (32'd10000 * {16'd0, h_word}) / 32'd65535;
               r.temp_centi = 15'(tq - 32'd4500);
               r.hum_centi  = 14'(hq);
               r.raw_temp   = t_word;
               r.raw_hum    = h_word;
               r.temp_ok    = t_ok;
               r.hum_ok     = h_ok;
               r.both_ok    = t_ok & h_ok;
               if (!r.both_ok) begin
                  bad_frames++;
               end
               reading_q.push_back(r);
               crc_acc  = sfccc_pkg::CRC_INIT;
               next_pos = sfccc_pkg::POS_TEMP_HI;
            end
         endcase
      endfunction

      task report(string what, logic signed [63:0] got, logic signed [63:0] want);
         $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
         errors++;
      endtask

      task compare_field(string what, logic signed [63:0] got, logic signed [63:0] want);
         if (got !== want) begin
            report(what, got, want);
         end
      endtask

      task check_result(logic [sfccc_pkg::RSP_DATA_W-1:0] data,
                        logic [sfccc_pkg::RSP_USER_W-1:0] flags);
         reading_type r;
         if (reading_q.size() == 0) begin
            report("unexpected word, raw_temperature", data[44:29], 0);
            return;
         end
         r = reading_q.pop_front();
         checked++;
         compare_field("temperature_centi", $signed(data[14:0]), $signed(r.temp_centi));
         compare_field("humidity_centi", data[28:15], r.hum_centi);
         compare_field("raw_temperature", data[44:29], r.raw_temp);
         compare_field("raw_humidity", data[60:45], r.raw_hum);
         compare_field("temp_crc_good", flags[0], r.temp_ok);
         compare_field("humid_crc_good", flags[1], r.hum_ok);
         compare_field("frame_valid", flags[2], r.both_ok);
      endtask
   endclass

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [7:0]                       req_tdata;
   logic [0:0]                       req_tuser;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [sfccc_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [sfccc_pkg::RSP_USER_W-1:0] rsp_tuser;

   frame_scoreboard sb = new();
   bit req_idle;
   bit rsp_idle;
   bit hold_request;
   int frames_sent;
   int holds_done;

   sensor_frame_crc_check_and_convert dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic send_byte(input logic [7:0] rx, input logic start);
      if (req_idle && $urandom_range(99) < 30) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom);
         @(posedge clock);
         while ($urandom_range(99) < 30) begin
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rx;
      req_tuser  <= start;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      sb.note_byte(rx, start);
   endtask

   task automatic send_frame(input logic [15:0] temp_raw, input logic [15:0] hum_raw,
                             input bit start, input bit temp_bad, input bit hum_bad);
      logic [7:0] tc;
      logic [7:0] hc;
      tc = frame_scoreboard::word_crc(temp_raw);
      hc = frame_scoreboard::word_crc(hum_raw);
      if (temp_bad) begin
         tc = tc ^ 8'($urandom_range(1, 255));
      end
      if (hum_bad) begin
         hc = hc ^ 8'($urandom_range(1, 255));
      end
      send_byte(temp_raw[15:8], start);
      send_byte(temp_raw[7:0], 1'b0);
      send_byte(tc, 1'b0);
      send_byte(hum_raw[15:8], 1'b0);
      send_byte(hum_raw[7:0], 1'b0);
      send_byte(hc, 1'b0);
      frames_sent++;
   endtask

   function automatic logic [15:0] pick_word();
      int r;
      r = $urandom_range(9);
      if (r == 0) begin
         return 16'h0000;
      end else if (r == 1) begin
         return 16'hFFFF;
      end
      return 16'($urandom);
   endfunction

   // output side: check accepted words, random stalls, long hold-offs on request
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            sb.check_result(rsp_tdata, rsp_tuser);
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
            holds_done++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_idle) begin
            rsp_tready <= ($urandom_range(99) >= 30);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int kind;
      int count;
      int next_hold;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = '0;
      rsp_tready   = 1'b0;
      req_idle     = 1'b1;
      rsp_idle     = 1'b1;
      hold_request = 1'b0;
      frames_sent  = 0;
      holds_done   = 0;
      next_hold    = 300;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // extremes, partial frame dropped by a new start, crc failures, back to back
      send_frame(16'h0000, 16'hFFFF, 1'b1, 1'b0, 1'b0);
      send_byte(8'hA5, 1'b1);
      send_byte(8'h5A, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_frame(16'h6666, 16'h8000, 1'b1, 1'b1, 1'b1);
      send_frame(16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0);
      send_frame(16'h8000, 16'h0001, 1'b0, 1'b1, 1'b0);

      while (sb.bytes_seen < TOTAL_BYTES) begin
         req_idle = !(sb.bytes_seen inside {[700:1100]});
         rsp_idle = req_idle;
         if (sb.bytes_seen >= next_hold) begin
            hold_request = 1'b1;
            next_hold    = next_hold + 1200;
         end
         kind = $urandom_range(99);
         if (kind < 80) begin
            send_frame(pick_word(), pick_word(), 1'($urandom_range(1)),
                       $urandom_range(99) < 20, $urandom_range(99) < 20);
         end else if (kind < 90) begin
            count = $urandom_range(1, 5);
            for (int i = 0; i < count; i++) begin
               send_byte(8'($urandom), i == 0);
            end
         end else begin
            count = $urandom_range(1, 8);
            for (int i = 0; i < count; i++) begin
               send_byte(8'($urandom), $urandom_range(99) < 20);
            end
         end
      end
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d bytes with %0d whole frames, checked %0d readings (%0d with crc failure)",
               sb.bytes_seen, frames_sent, sb.checked, sb.bad_frames);
      $display("included partial frames, resync noise and %0d long output hold-offs",
               holds_done);
      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
